### hw/rtl/assert_macros.svh
// Assertion macros for the allocator RTL; included only by pfbf_dpath.
// Uses the module's i_clk and i_rst_n; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/pfbf_pkg.sv
// Shared types and constants of the partition allocator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package pfbf_pkg;
    localparam int ADDR_BITS     = 16;
    localparam int OWNER_BITS    = 8;
    localparam int MAX_PARTS_DEF = 16;
    localparam logic [ADDR_BITS-1:0] MEM_SIZE_RST = 16'd640;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_NOFIT   = 3'd2,
        ST_NOOWNER = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_SCAN_A, CMD_SCAN_F, CMD_MARK, CMD_INS_START,
        CMD_INS_SHIFT, CMD_INS_FILL, CMD_INS_FILL2, CMD_RIGHT, CMD_LEFT,
        CMD_SHDN, CMD_DEC, CMD_RESULT
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code code;
        t_status   status;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic req_zero;
        logic scan_done;
        logic found;
        logic exact;
        logic full;
        logic ins_done;
        logic shdn_done;
        logic merged;
        logic out_busy;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SCAN_A, S_EVAL, S_INS, S_FILL2, S_SCAN_F, S_RIGHT,
        S_RCHK, S_SHDN_R, S_LEFT, S_LCHK, S_SHDN_L, S_RESULT
    } t_state;
endpackage
`default_nettype wire

### hw/rtl/pfbf_ctrl.sv
// Sequencer of the partition allocator: walks scan, split and merge steps.
// Depends on pfbf_pkg; drives commands into pfbf_dpath.
`default_nettype none
module pfbf_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  pfbf_pkg::t_dp_stat i_stat,
    output pfbf_pkg::t_cmd    o_cmd
);
    import pfbf_pkg::*;

    t_state  r_state, n_state;
    t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        o_cmd.code  = CMD_NONE;
        o_cmd.status = r_status;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.code = CMD_LOAD;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_free) begin
                    n_state = S_SCAN_F;
                end else if (i_stat.req_zero) begin
                    n_status = ST_ZERO;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_SCAN_A;
                end
            end
            S_SCAN_A: begin
                if (i_stat.scan_done) n_state = S_EVAL;
                else o_cmd.code = CMD_SCAN_A;
            end
            S_EVAL: begin
                if (!i_stat.found) begin
                    n_status = ST_NOFIT;
                    n_state  = S_RESULT;
                end else if (i_stat.exact) begin
                    o_cmd.code = CMD_MARK;
                    n_status   = ST_OK;
                    n_state    = S_RESULT;
                end else if (i_stat.full) begin
                    n_status = ST_FULL;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.code = CMD_INS_START;
                    n_state    = S_INS;
                end
            end
            S_INS: begin
                if (i_stat.ins_done) begin
                    o_cmd.code = CMD_INS_FILL;
                    n_state    = S_FILL2;
                end else begin
                    o_cmd.code = CMD_INS_SHIFT;
                end
            end
            S_FILL2: begin
                o_cmd.code = CMD_INS_FILL2;
                n_status   = ST_OK;
                n_state    = S_RESULT;
            end
            S_SCAN_F: begin
                if (i_stat.found) begin
                    n_state = S_RIGHT;
                end else if (i_stat.scan_done) begin
                    n_status = ST_NOOWNER;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.code = CMD_SCAN_F;
                end
            end
            S_RIGHT: begin
                o_cmd.code = CMD_RIGHT;
                n_state    = S_RCHK;
            end
            S_RCHK: n_state = i_stat.merged ? S_SHDN_R : S_LEFT;
            S_SHDN_R: begin
                if (i_stat.shdn_done) begin
                    o_cmd.code = CMD_DEC;
                    n_state    = S_LEFT;
                end else begin
                    o_cmd.code = CMD_SHDN;
                end
            end
            S_LEFT: begin
                o_cmd.code = CMD_LEFT;
                n_state    = S_LCHK;
            end
            S_LCHK: begin
                n_status = ST_OK;
                n_state  = i_stat.merged ? S_SHDN_L : S_RESULT;
            end
            S_SHDN_L: begin
                if (i_stat.shdn_done) begin
                    o_cmd.code = CMD_DEC;
                    n_state    = S_RESULT;
                end else begin
                    o_cmd.code = CMD_SHDN;
                end
            end
            S_RESULT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.code = CMD_RESULT;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### hw/rtl/pfbf_dpath.sv
// Partition table, scan registers and result register of the allocator.
// Depends on pfbf_pkg and assert_macros.svh; commanded by pfbf_ctrl.
`default_nettype none
`include "assert_macros.svh"
module pfbf_dpath #(
    parameter int MAX_PARTS = pfbf_pkg::MAX_PARTS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  pfbf_pkg::t_cmd                   i_cmd,
    output pfbf_pkg::t_dp_stat               o_stat,
    input  wire                              i_load_op,
    input  wire [pfbf_pkg::ADDR_BITS-1:0]    i_load_req,
    input  wire [pfbf_pkg::OWNER_BITS-1:0]   i_load_own,
    input  wire                              i_strategy,
    input  wire                              i_init,
    input  wire [pfbf_pkg::ADDR_BITS-1:0]    i_init_size,
    input  wire                              i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_out_success,
    output logic [pfbf_pkg::ADDR_BITS-1:0]   o_out_addr,
    output logic [2:0]                       o_out_status
);
    import pfbf_pkg::*;

    localparam int IW = $clog2(MAX_PARTS);
    localparam int CW = $clog2(MAX_PARTS + 1);

    logic [ADDR_BITS-1:0]  r_start [MAX_PARTS];
    logic [ADDR_BITS-1:0]  r_size  [MAX_PARTS];
    logic [OWNER_BITS-1:0] r_owner [MAX_PARTS];
    logic [MAX_PARTS-1:0]  r_used;

    logic [CW-1:0]         r_count, r_k;
    logic [IW-1:0]         r_pick;
    logic                  r_found, r_merged, r_op;
    logic [ADDR_BITS-1:0]  r_req, r_psize, r_paddr;
    logic [OWNER_BITS-1:0] r_own;

    logic [CW-1:0]         rd_sel, pick_w, pick_p1, pick_m1;
    logic [IW-1:0]         rd_idx, wr_idx;
    logic [ADDR_BITS-1:0]  rd_start, rd_size, wd_start, wd_size;
    logic [OWNER_BITS-1:0] rd_owner, wd_owner;
    logic                  rd_used, wd_used;
    logic                  we_start, we_size, we_used, we_owner;
    logic                  a_hit, f_hit, r_cond, l_cond;

    assign pick_w  = CW'(r_pick);
    assign pick_p1 = pick_w + CW'(1);
    assign pick_m1 = pick_w - CW'(1);

    always_comb begin
        unique case (i_cmd.code)
            CMD_INS_SHIFT: rd_sel = r_k - CW'(1);
            CMD_SHDN:      rd_sel = r_k + CW'(1);
            CMD_RIGHT:     rd_sel = pick_p1;
            CMD_LEFT:      rd_sel = pick_m1;
            default:       rd_sel = r_k;
        endcase
    end

    assign rd_idx   = rd_sel[IW-1:0];
    assign rd_start = r_start[rd_idx];
    assign rd_size  = r_size[rd_idx];
    assign rd_owner = r_owner[rd_idx];
    assign rd_used  = r_used[rd_idx];

    assign a_hit  = !rd_used && (rd_size >= r_req) && (!r_found || rd_size < r_psize);
    assign f_hit  = rd_used && (rd_owner == r_own);
    assign r_cond = (pick_p1 < r_count) && !rd_used;
    assign l_cond = (r_pick != '0) && !rd_used;

    // One table write per cycle; the command picks the entry and the fields.
    always_comb begin
        wr_idx   = r_k[IW-1:0];
        wd_start = rd_start;
        wd_size  = rd_size;
        wd_used  = rd_used;
        wd_owner = rd_owner;
        we_start = 1'b0;
        we_size  = 1'b0;
        we_used  = 1'b0;
        we_owner = 1'b0;
        unique case (i_cmd.code)
            CMD_SCAN_F: if (f_hit) begin
                wd_used  = 1'b0;
                wd_owner = '0;
                we_used  = 1'b1;
                we_owner = 1'b1;
            end
            CMD_MARK: begin
                wr_idx   = r_pick;
                wd_used  = 1'b1;
                wd_owner = r_own;
                we_used  = 1'b1;
                we_owner = 1'b1;
            end
            CMD_INS_SHIFT, CMD_SHDN: begin
                we_start = 1'b1;
                we_size  = 1'b1;
                we_used  = 1'b1;
                we_owner = 1'b1;
            end
            CMD_INS_FILL: begin
                wr_idx   = r_pick;
                wd_start = r_paddr;
                wd_size  = r_req;
                wd_used  = 1'b1;
                wd_owner = r_own;
                we_start = 1'b1;
                we_size  = 1'b1;
                we_used  = 1'b1;
                we_owner = 1'b1;
            end
            CMD_INS_FILL2: begin
                wr_idx   = pick_p1[IW-1:0];
                wd_start = r_paddr + r_req;
                wd_size  = r_psize - r_req;
                wd_used  = 1'b0;
                we_start = 1'b1;
                we_size  = 1'b1;
                we_used  = 1'b1;
            end
            CMD_RIGHT: begin
                wr_idx  = r_pick;
                wd_size = r_psize + rd_size;
                we_size = r_cond;
            end
            CMD_LEFT: begin
                wr_idx  = pick_m1[IW-1:0];
                wd_size = rd_size + r_psize;
                we_size = l_cond;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_start[0] <= '0;
            r_size[0]  <= i_rst_n ? i_init_size : MEM_SIZE_RST;
        end else begin
            if (we_start) r_start[wr_idx] <= wd_start;
            if (we_size)  r_size[wr_idx]  <= wd_size;
        end
        if (we_owner) r_owner[wr_idx] <= wd_owner;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_used  <= '0;
            r_count <= CW'(1);
        end else begin
            if (we_used) r_used[wr_idx] <= wd_used;
            if (i_cmd.code == CMD_INS_FILL2) r_count <= r_count + CW'(1);
            if (i_cmd.code == CMD_DEC && r_count > CW'(1)) r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= 1'b0;
            r_merged <= 1'b0;
            r_k      <= '0;
        end else begin
            unique case (i_cmd.code)
                CMD_LOAD: begin
                    r_found <= 1'b0;
                    r_k     <= '0;
                end
                CMD_SCAN_A: begin
                    if (a_hit) begin
                        r_found <= 1'b1;
                        r_pick  <= rd_idx;
                        r_psize <= rd_size;
                        r_paddr <= rd_start;
                    end
                    r_k <= r_k + CW'(1);
                end
                CMD_SCAN_F: begin
                    if (f_hit) begin
                        r_found <= 1'b1;
                        r_pick  <= rd_idx;
                        r_psize <= rd_size;
                        r_paddr <= rd_start;
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
                CMD_INS_START: r_k <= r_count;
                CMD_INS_SHIFT: r_k <= r_k - CW'(1);
                CMD_SHDN:      r_k <= r_k + CW'(1);
                CMD_RIGHT: begin
                    r_merged <= r_cond;
                    if (r_cond) begin
                        r_psize <= wd_size;
                        r_k     <= pick_p1;
                    end
                end
                CMD_LEFT: begin
                    r_merged <= l_cond;
                    if (l_cond) r_k <= pick_w;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.code == CMD_LOAD) begin
            r_op  <= i_load_op;
            r_req <= i_load_req;
            r_own <= i_load_own;
        end
    end

    // Result register: a finished item waits here while the next one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.code == CMD_RESULT) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.code == CMD_RESULT) begin
            o_out_success <= (i_cmd.status == ST_OK);
            o_out_addr    <= (i_cmd.status == ST_OK) ? r_paddr : '0;
            o_out_status  <= i_cmd.status;
        end
    end

    always_comb begin
        o_stat.is_free   = (r_op == OP_FREE);
        o_stat.req_zero  = (r_req == '0);
        o_stat.scan_done = (r_k >= r_count) || (!r_op && !i_strategy && r_found);
        o_stat.found     = r_found;
        o_stat.exact     = (r_psize == r_req);
        o_stat.full      = (r_count >= CW'(MAX_PARTS));
        o_stat.ins_done  = (r_k == pick_w);
        o_stat.shdn_done = ((r_k + CW'(1)) >= r_count);
        o_stat.merged    = r_merged;
        o_stat.out_busy  = o_out_valid && !i_out_ready;
    end

    `ASSERT_IMP(a_count_range, 1'b1, (r_count != '0) && (r_count <= CW'(MAX_PARTS)))
    `ASSERT_IMP(a_scan_in_table, (i_cmd.code == CMD_SCAN_A) || (i_cmd.code == CMD_SCAN_F), r_k < r_count)
    `ASSERT_NEXT(a_split_grows, (i_cmd.code == CMD_INS_FILL2) && !i_init, r_count == $past(r_count) + CW'(1))
    `ASSERT_IMP(a_split_has_room, i_cmd.code == CMD_INS_START, r_count < CW'(MAX_PARTS))
endmodule
`default_nettype wire

### hw/rtl/partition_first_best_fit_allocator_core.sv
// A zero-size allocate goes straight to the result; an allocate scans the table, and a split
// also shifts the entries above the picked one up by one; a free scans for the owner's entry
// and merges it with a free right and then left neighbour, shifting the later entries down
// for each merge. One table access per cycle. One item at a time; the next is taken once the
// result is registered, and a stalled result holds the block. Reset (synchronous, active
// low) leaves one free partition of 640 units, first fit. Uses pfbf_pkg, pfbf_ctrl, pfbf_dpath.
`default_nettype none
module partition_first_best_fit_allocator_core #(
    parameter int MAX_PARTS = pfbf_pkg::MAX_PARTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [23:0] i_s_axis_tdata,  // [15:0] request_size, [23:16] owner_id
    input  wire         i_s_axis_tuser,  // [0] op
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [15:0] start_address, [18:16] status, rest zero
    output logic        o_m_axis_tuser,  // [0] success
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfbf_pkg::*;

    localparam logic REG_FIT = 1'b0;
    localparam logic REG_MEM = 1'b1;

    logic                 r_strategy;
    logic [ADDR_BITS-1:0] r_mem_size;
    logic                 cfg_wr, init;
    t_cmd                 cmd;
    t_dp_stat             stat;
    logic [ADDR_BITS-1:0] out_addr;
    logic [2:0]           out_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign init   = cfg_wr && (paddr[2] == REG_MEM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy <= 1'b0;
            r_mem_size <= MEM_SIZE_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_FIT) r_strategy <= pwdata[0];
            else r_mem_size <= pwdata[ADDR_BITS-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FIT: prdata = {31'd0, r_strategy};
            default: prdata = {{(32-ADDR_BITS){1'b0}}, r_mem_size};
        endcase
    end

    pfbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pfbf_dpath #(.MAX_PARTS(MAX_PARTS)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_load_op     (i_s_axis_tuser),
        .i_load_req    (i_s_axis_tdata[15:0]),
        .i_load_own    (i_s_axis_tdata[23:16]),
        .i_strategy    (r_strategy),
        .i_init        (init),
        .i_init_size   (pwdata[ADDR_BITS-1:0]),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_success (o_m_axis_tuser),
        .o_out_addr    (out_addr),
        .o_out_status  (out_status)
    );

    assign o_m_axis_tdata = {5'd0, out_status, out_addr};
endmodule
`default_nettype wire

### tb/partition_first_best_fit_allocator_core_tb.sv
// Testbench of the partition allocator core: drives allocate and free items on the
// input stream, predicts each result and checks the result stream field by field.
// Depends on pfbf_pkg and partition_first_best_fit_allocator_core.
`timescale 1ns / 100ps
`default_nettype none

module partition_first_best_fit_allocator_core_tb;
    import pfbf_pkg::*;

    localparam int NPARTS = MAX_PARTS_DEF;
    localparam logic [2:0] REG_STRATEGY = 3'd0;
    localparam logic [2:0] REG_MEMSIZE  = 3'd4;

    typedef struct packed {
        logic    ok;
        logic [15:0] addr;
        t_status status;
    } t_alloc_result;

    class alloc_scoreboard;
        logic        use_smallest;
        logic [15:0] region_size;
        logic [15:0] p_start [NPARTS];
        logic [15:0] p_size [NPARTS];
        logic        p_used [NPARTS];
        logic [7:0]  p_owner [NPARTS];
        int          nparts;
        t_alloc_result pending [$];
        int          errors;

        function void init_table();
            for (int k = 0; k < NPARTS; k++) begin
                p_start[k] = 0; p_size[k] = 0; p_used[k] = 0; p_owner[k] = 0;
            end
            p_size[0] = region_size;
            nparts = 1;
        endfunction

        function void set_strategy(logic v);
            use_smallest = v;
        endfunction

        function void set_region(logic [15:0] v);
            region_size = v;
            init_table();
        endfunction

        function void drop_entry(int i);
            for (int k = i; k + 1 < nparts; k++) begin
                p_start[k] = p_start[k+1]; p_size[k] = p_size[k+1];
                p_used[k] = p_used[k+1]; p_owner[k] = p_owner[k+1];
            end
            if (nparts > 1) nparts--;
        endfunction

        // Works out the result of one accepted request and updates the table.
        function void note_request(t_op op, logic [15:0] req, logic [7:0] owner);
            t_alloc_result r;
            int pick;
            int i;
            logic [15:0] a;
            r = '{ok: 1'b0, addr: 16'd0, status: ST_OK};
            if (op == OP_ALLOC) begin
                pick = -1;
                if (req == 0) begin
                    r.status = ST_ZERO;
                end else begin
                    for (i = 0; i < nparts; i++) begin
                        if (!p_used[i] && p_size[i] >= req) begin
                            if (pick < 0 || p_size[i] < p_size[pick]) pick = i;
                            if (!use_smallest) break;
                        end
                    end
                    if (pick < 0) begin
                        r.status = ST_NOFIT;
                    end else if (p_size[pick] == req) begin
                        p_used[pick] = 1; p_owner[pick] = owner;
                        r = '{ok: 1'b1, addr: p_start[pick], status: ST_OK};
                    end else if (nparts >= NPARTS) begin
                        r.status = ST_FULL;
                    end else begin
                        a = p_start[pick];
                        for (int k = nparts; k > pick; k--) begin
                            p_start[k] = p_start[k-1]; p_size[k] = p_size[k-1];
                            p_used[k] = p_used[k-1]; p_owner[k] = p_owner[k-1];
                        end
                        nparts++;
                        p_size[pick] = req; p_used[pick] = 1; p_owner[pick] = owner;
                        p_start[pick+1] = a + req;
                        p_size[pick+1] = p_size[pick+1] - req;
                        r = '{ok: 1'b1, addr: a, status: ST_OK};
                    end
                end
            end else begin
                for (i = 0; i < nparts; i++)
                    if (p_used[i] && p_owner[i] == owner) break;
                if (i >= nparts) begin
                    r.status = ST_NOOWNER;
                end else begin
                    r = '{ok: 1'b1, addr: p_start[i], status: ST_OK};
                    p_used[i] = 0; p_owner[i] = 0;
                    if (i + 1 < nparts && !p_used[i+1]) begin
                        p_size[i] = p_size[i] + p_size[i+1];
                        drop_entry(i + 1);
                    end
                    if (i > 0 && !p_used[i-1]) begin
                        p_size[i-1] = p_size[i-1] + p_size[i];
                        drop_entry(i);
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic ok, logic [15:0] addr, logic [2:0] status,
                                   logic [23:0] raw);
            t_alloc_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result ok=%0b addr=%0d status=%0d",
                         $time, ok, addr, status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ok !== e.ok) begin
                $display("%0t: success expected %0b actual %0b", $time, e.ok, ok);
                errors++;
            end
            if (addr !== e.addr) begin
                $display("%0t: start_address expected %0d actual %0d", $time, e.addr, addr);
                errors++;
            end
            if (status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                errors++;
            end
            if (raw[23:19] !== 5'd0) begin
                $display("%0t: tdata pad expected 0 actual %0h", $time, raw[23:19]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        m_ready = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         s_ready, m_valid, m_user, pready;
    wire  [23:0] m_data;
    wire  [31:0] prdata;
    int          hold_cnt = 0;

    alloc_scoreboard sb;

    partition_first_best_fit_allocator_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_reg(logic [2:0] addr, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == REG_STRATEGY) sb.set_strategy(val[0]);
        else sb.set_region(val[15:0]);
        @(posedge i_clk);
    endtask

    // With no gap the next item follows at once, so tvalid stays high.
    task automatic send_request(t_op op, logic [15:0] req, logic [7:0] owner);
        int g;
        s_valid <= 1'b1; s_data <= {owner, req}; s_user <= op;
        do @(posedge i_clk); while (!s_ready);
        sb.note_request(op, req, owner);
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Waits until every expected result is back, plus the longest scan and shift.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Mostly well-formed allocate and free items over a few owners, with some noise.
    task automatic random_phase(int n, logic [15:0] region);
        int p;
        logic [15:0] sz;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 99);
            if (p < 4) sz = 0;
            else if (p < 10) sz = 16'($urandom_range(0, 65535));
            else if (p < 20) sz = region;
            else sz = 16'($urandom_range(1, (region > 8 * 1) ? region / 6 + 1 : 2));
            if ($urandom_range(0, 99) < 55)
                send_request(OP_ALLOC, sz, $urandom_range(0, 99) < 90 ?
                             8'($urandom_range(0, 11)) : 8'($urandom_range(0, 255)));
            else
                send_request(OP_FREE, 16'($urandom_range(0, 65535)),
                             $urandom_range(0, 99) < 90 ?
                             8'($urandom_range(0, 11)) : 8'($urandom_range(0, 255)));
        end
    endtask

    // Result side: ready is held low for a random stall between ready cycles, often none.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            sb.check_result(m_user, m_data[15:0], m_data[18:16], m_data);
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready  <= 1'b1;
            hold_cnt <= gap_len();
        end
    end

    initial begin
        sb = new();
        sb.errors = 0;
        sb.use_smallest = 0;
        sb.set_region(16'd640);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero size, exact fit, splits, merges, unknown owner, big sizes.
        send_request(OP_ALLOC, 16'd0, 8'd1);
        send_request(OP_ALLOC, 16'hFFFF, 8'd1);
        send_request(OP_ALLOC, 16'd100, 8'd1);
        send_request(OP_ALLOC, 16'd200, 8'd2);
        send_request(OP_ALLOC, 16'd50, 8'hFF);
        send_request(OP_FREE, 16'hFFFF, 8'd7);
        send_request(OP_FREE, 16'd0, 8'd1);
        send_request(OP_FREE, 16'd0, 8'hFF);
        send_request(OP_FREE, 16'd0, 8'd2);
        send_request(OP_ALLOC, 16'd640, 8'd0);
        send_request(OP_FREE, 16'd0, 8'd0);
        drain();
        write_reg(REG_STRATEGY, 32'd1);
        write_reg(REG_MEMSIZE, 32'd300);
        send_request(OP_ALLOC, 16'd30, 8'd1);
        send_request(OP_ALLOC, 16'd10, 8'd2);
        send_request(OP_ALLOC, 16'd40, 8'd3);
        send_request(OP_FREE, 16'd0, 8'd1);
        send_request(OP_FREE, 16'd0, 8'd3);
        send_request(OP_ALLOC, 16'd25, 8'd4);
        // Fill the table with unit splits to reach the full case.
        for (int k = 0; k < 14; k++) send_request(OP_ALLOC, 16'd1, 8'(k + 20));
        drain();
        write_reg(REG_MEMSIZE, 32'd0);
        send_request(OP_ALLOC, 16'd1, 8'd1);
        drain();
        write_reg(REG_MEMSIZE, 32'hFFFF);
        send_request(OP_ALLOC, 16'hFFFF, 8'd9);
        send_request(OP_FREE, 16'd0, 8'd9);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            logic [15:0] region;
            case (ph)
                0: region = 640;
                1: region = 1;
                2: region = 65535;
                default: region = 16'($urandom_range(2, 2000));
            endcase
            write_reg(REG_STRATEGY, ph % 2);
            write_reg(REG_MEMSIZE, 32'(region));
            random_phase(200, region);
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/pfbf_pkg.sv
hw/rtl/pfbf_ctrl.sv
hw/rtl/pfbf_dpath.sv
hw/rtl/partition_first_best_fit_allocator_core.sv
tb/partition_first_best_fit_allocator_core_tb.sv
